### rtl/assert_macros.svh
// Assertion helpers included by tree_object_entry_parser.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante, outside reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: ante |-> cons");

// Check that cons holds in the cycle after ante; reset is not masked.
`define ASSERT_NEXT(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed: ante |=> cons");

`endif

### rtl/toep_pkg.sv
package toep_pkg;

    // Result kinds
    localparam logic [2:0] KIND_NAME_BYTE  = 3'd0;
    localparam logic [2:0] KIND_HASH_BYTE  = 3'd1;
    localparam logic [2:0] KIND_ENTRY_DONE = 3'd2;
    localparam logic [2:0] KIND_END_OK     = 3'd3;
    localparam logic [2:0] KIND_ERROR      = 3'd4;

    // Error codes
    localparam logic [1:0] ERR_MODE_LONG = 2'd0;
    localparam logic [1:0] ERR_NAME_LONG = 2'd1;
    localparam logic [1:0] ERR_TRUNCATED = 2'd2;

    // Parser phases
    localparam logic [1:0] PH_MODE = 2'd0;
    localparam logic [1:0] PH_NAME = 2'd1;
    localparam logic [1:0] PH_HASH = 2'd2;

    // Special bytes
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_SEVEN = 8'h37;

    // Queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;
    localparam int Q_CW    = 3;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  byte_value;
        logic [7:0]  byte_position;
        logic [31:0] entry_mode;
        logic [10:0] entry_number;
        logic [1:0]  error_code;
        logic        run_end;
    } t_result;

    // Up to two results caused by one byte
    typedef struct packed {
        logic    has_second;
        t_result first;
        t_result second;
    } t_pair;

endpackage

### rtl/toep_front.sv
module toep_front
    import toep_pkg::*;
#(
    parameter int MAX_ENTRIES        = 1024,
    parameter int DIGEST_BYTES       = 32,
    parameter int NAME_CAPACITY      = 256,
    parameter int MODE_TEXT_CAPACITY = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_data_byte,
    input  logic       i_final_byte,
    output logic       o_push,
    output t_pair      o_pair
);

    localparam int EW = $clog2(MAX_ENTRIES + 1);
    localparam int HW = (DIGEST_BYTES > 1) ? $clog2(DIGEST_BYTES) : 1;
    localparam int NW = $clog2(NAME_CAPACITY);
    localparam int MW = $clog2(MODE_TEXT_CAPACITY);

    logic [1:0]    r_phase, n_phase;
    logic [31:0]   r_mode, n_mode;
    logic [MW-1:0] r_mode_len, n_mode_len;
    logic          r_stopped, n_stopped;
    logic [NW-1:0] r_name_len, n_name_len;
    logic [HW-1:0] r_hash_len, n_hash_len;
    logic [EW-1:0] r_entries, n_entries;
    logic          r_failed, n_failed;

    logic          active;
    logic          a_vld, b_vld;
    t_result       res_a, res_b;
    logic [15:0]   name_ext, hash_ext, ent_ext;

    assign name_ext     = 16'(r_name_len);
    assign hash_ext     = 16'(r_hash_len);
    assign ent_ext      = 16'(r_entries);

    // Classify the byte and work out the next parser state
    always_comb begin
        n_phase    = r_phase;
        n_mode     = r_mode;
        n_mode_len = r_mode_len;
        n_stopped  = r_stopped;
        n_name_len = r_name_len;
        n_hash_len = r_hash_len;
        n_entries  = r_entries;
        n_failed   = r_failed;
        res_a      = '0;
        res_b      = '0;
        a_vld      = 1'b0;
        b_vld      = 1'b0;
        active     = !r_failed && (r_entries < EW'(MAX_ENTRIES));

        if (active) begin
            case (r_phase)
                PH_NAME: begin
                    if (i_data_byte == CH_NUL) begin
                        n_phase    = PH_HASH;
                        n_hash_len = '0;
                    end else if (r_name_len == NW'(NAME_CAPACITY - 1)) begin
                        a_vld            = 1'b1;
                        res_a.kind       = KIND_ERROR;
                        res_a.error_code = ERR_NAME_LONG;
                        n_failed         = 1'b1;
                    end else begin
                        a_vld               = 1'b1;
                        res_a.kind          = KIND_NAME_BYTE;
                        res_a.byte_value    = i_data_byte;
                        res_a.byte_position = name_ext[7:0];
                        n_name_len          = r_name_len + NW'(1);
                    end
                end
                PH_HASH: begin
                    a_vld               = 1'b1;
                    res_a.byte_value    = i_data_byte;
                    res_a.byte_position = hash_ext[7:0];
                    if (r_hash_len == HW'(DIGEST_BYTES - 1)) begin
                        res_a.kind         = KIND_ENTRY_DONE;
                        res_a.entry_mode   = r_mode;
                        res_a.entry_number = ent_ext[10:0];
                        n_entries          = r_entries + EW'(1);
                        n_phase            = PH_MODE;
                        n_mode             = '0;
                        n_mode_len         = '0;
                        n_stopped          = 1'b0;
                        n_name_len         = '0;
                        n_hash_len         = '0;
                    end else begin
                        res_a.kind = KIND_HASH_BYTE;
                        n_hash_len = r_hash_len + HW'(1);
                    end
                end
                default: begin
                    if (i_data_byte == CH_SPACE) begin
                        n_phase    = PH_NAME;
                        n_name_len = '0;
                    end else if (r_mode_len == MW'(MODE_TEXT_CAPACITY - 1)) begin
                        a_vld            = 1'b1;
                        res_a.kind       = KIND_ERROR;
                        res_a.error_code = ERR_MODE_LONG;
                        n_failed         = 1'b1;
                    end else begin
                        n_mode_len = r_mode_len + MW'(1);
                        if (!r_stopped && (i_data_byte inside {[CH_ZERO:CH_SEVEN]})) begin
                            n_mode = {r_mode[28:0], i_data_byte[2:0]};
                        end else begin
                            n_stopped = 1'b1;
                        end
                    end
                end
            endcase

            // Flag an entry left unfinished by the last byte
            if (i_final_byte && !n_failed && !(n_phase == PH_MODE && n_mode_len == '0)) begin
                b_vld            = 1'b1;
                res_b.kind       = KIND_ERROR;
                res_b.error_code = ERR_TRUNCATED;
                n_failed         = 1'b1;
            end
        end

        // Close the object and return to the reset state
        if (i_final_byte) begin
            if (!n_failed) begin
                b_vld              = 1'b1;
                res_b.kind         = KIND_END_OK;
                res_b.entry_number = 11'(n_entries);
            end
            n_phase    = PH_MODE;
            n_mode     = '0;
            n_mode_len = '0;
            n_stopped  = 1'b0;
            n_name_len = '0;
            n_hash_len = '0;
            n_entries  = '0;
            n_failed   = 1'b0;
        end
    end

    // Pack the results in order and mark the last one
    always_comb begin
        o_pair            = '0;
        o_pair.has_second = a_vld && b_vld;
        o_pair.first      = a_vld ? res_a : res_b;
        o_pair.second     = res_b;
        if (a_vld && b_vld) begin
            o_pair.second.run_end = 1'b1;
        end else begin
            o_pair.first.run_end = 1'b1;
        end
    end

    assign o_push = i_accept && (a_vld || b_vld);

    // Advance the parser state on each transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_MODE;
            r_mode     <= '0;
            r_mode_len <= '0;
            r_stopped  <= 1'b0;
            r_name_len <= '0;
            r_hash_len <= '0;
            r_entries  <= '0;
            r_failed   <= 1'b0;
        end else if (i_accept) begin
            r_phase    <= n_phase;
            r_mode     <= n_mode;
            r_mode_len <= n_mode_len;
            r_stopped  <= n_stopped;
            r_name_len <= n_name_len;
            r_hash_len <= n_hash_len;
            r_entries  <= n_entries;
            r_failed   <= n_failed;
        end
    end

endmodule

### rtl/toep_queue.sv
module toep_queue
    import toep_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_pair i_pair,
    input  logic  i_deq,
    output t_pair o_head,
    output logic  o_empty,
    output logic  o_full
);

    t_pair           r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr, r_rd;
    logic [Q_CW-1:0] r_count;
    logic            do_wr, do_rd;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == Q_CW'(Q_DEPTH));
    assign o_head  = r_mem[r_rd];
    assign do_wr   = i_push && !o_full;
    assign do_rd   = i_deq && !o_empty;

    // Store pushed pairs
    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr] <= i_pair;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_wr) begin
                r_wr <= r_wr + Q_AW'(1);
            end
            if (do_rd) begin
                r_rd <= r_rd + Q_AW'(1);
            end
            case ({do_wr, do_rd})
                2'b10:   r_count <= r_count + Q_CW'(1);
                2'b01:   r_count <= r_count - Q_CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

### rtl/toep_back.sv
module toep_back
    import toep_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_pair   i_head,
    input  logic    i_q_empty,
    output logic    o_deq,
    input  logic    i_pop,
    output logic    o_empty,
    output t_result o_result
);

    logic    r_out_vld, r_pend_vld;
    t_result r_out, r_pend;
    logic    slot_free;

    assign slot_free = !r_out_vld || i_pop;
    assign o_deq     = slot_free && !r_pend_vld && !i_q_empty;
    assign o_empty   = !r_out_vld;
    assign o_result  = r_out;

    // Refill the output register from the held second result or the queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_pend_vld <= 1'b0;
        end else if (slot_free) begin
            if (r_pend_vld) begin
                r_out_vld  <= 1'b1;
                r_pend_vld <= 1'b0;
            end else if (!i_q_empty) begin
                r_out_vld  <= 1'b1;
                r_pend_vld <= i_head.has_second;
            end else begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (slot_free) begin
            if (r_pend_vld) begin
                r_out <= r_pend;
            end else if (!i_q_empty) begin
                r_out  <= i_head.first;
                r_pend <= i_head.second;
            end
        end
    end

endmodule

### rtl/tree_object_entry_parser.sv
// Channel  | Handshake             | Payload
// ---------+-----------------------+------------------------------------------
// input    | i_push / o_full       | i_data_byte, i_final_byte
// result   | o_empty / i_pop       | o_kind, o_byte_value, o_byte_position,
//          |                       | o_entry_mode, o_entry_number,
//          |                       | o_error_code, o_run_end
//
// One byte is taken per cycle unless o_full; each taken byte updates parser state.
// A byte yields up to two results; the output register drains one per i_pop cycle.
// Results pass the queue, then the output register; 4-pair queue sets stall slack.
// Reset (i_rst_n low, synchronous) clears parser state, queue and output register.
`include "assert_macros.svh"

module tree_object_entry_parser
    import toep_pkg::*;
#(
    parameter int MAX_ENTRIES        = 1024,
    parameter int DIGEST_BYTES       = 32,
    parameter int NAME_CAPACITY      = 256,
    parameter int MODE_TEXT_CAPACITY = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_final_byte,
    output logic        o_empty,
    input  logic        i_pop,
    output logic [2:0]  o_kind,
    output logic [7:0]  o_byte_value,
    output logic [7:0]  o_byte_position,
    output logic [31:0] o_entry_mode,
    output logic [10:0] o_entry_number,
    output logic [1:0]  o_error_code,
    output logic        o_run_end
);

    logic    accept, q_push, q_deq, q_empty, q_full;
    t_pair   q_in, q_head;
    t_result res;

    assign accept = i_push && !q_full;
    assign o_full = q_full;

    // Parse bytes
    toep_front #(
        .MAX_ENTRIES        (MAX_ENTRIES),
        .DIGEST_BYTES       (DIGEST_BYTES),
        .NAME_CAPACITY      (NAME_CAPACITY),
        .MODE_TEXT_CAPACITY (MODE_TEXT_CAPACITY)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_data_byte  (i_data_byte),
        .i_final_byte (i_final_byte),
        .o_push       (q_push),
        .o_pair       (q_in)
    );

    // Decouple parse from delivery
    toep_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_pair  (q_in),
        .i_deq   (q_deq),
        .o_head  (q_head),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    // Deliver results one at a time
    toep_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_head    (q_head),
        .i_q_empty (q_empty),
        .o_deq     (q_deq),
        .i_pop     (i_pop),
        .o_empty   (o_empty),
        .o_result  (res)
    );

    assign o_kind          = res.kind;
    assign o_byte_value    = res.byte_value;
    assign o_byte_position = res.byte_position;
    assign o_entry_mode    = res.entry_mode;
    assign o_entry_number  = res.entry_number;
    assign o_error_code    = res.error_code;
    assign o_run_end       = res.run_end;

    // The last hash byte always travels with the entry-done result
    `ASSERT_IMPLY(a_hash_pos, i_clk, i_rst_n, !o_empty && o_kind == KIND_HASH_BYTE, o_byte_position < 8'(DIGEST_BYTES - 1))

    // Error results carry only a valid code
    `ASSERT_IMPLY(a_err_clean, i_clk, i_rst_n, !o_empty && o_kind == KIND_ERROR, o_error_code != 2'd3 && o_entry_mode == '0 && o_byte_value == '0)

    // Reset leaves both sides idle
    `ASSERT_NEXT(a_reset_idle, i_clk, !i_rst_n, o_empty && !o_full)

endmodule
